// File: rtl/swkr_pkg.sv
`default_nettype none
package swkr_pkg;

	localparam logic [1:0] CMD_PUSH   = 2'd0;
	localparam logic [1:0] CMD_POP    = 2'd1;
	localparam logic [1:0] CMD_REMOVE = 2'd2;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	typedef struct packed {
		logic [1:0]         command;
		logic signed [31:0] value;
	} cmd_word_t;

	typedef struct packed {
		logic signed [31:0] popped_value;
		logic [1:0]         status;
		logic [7:0]         fill_level;
	} rsp_word_t;

endpackage
`default_nettype wire

// File: rtl/stack_with_key_removal_unit.sv
`default_nettype none
// LIFO stack of DEPTH signed 32-bit words held in a single-port-write, registered-read
// memory, with push, pop and remove-all-matching commands. Every command word gives
// exactly one response word. Push, a refused push or pop, and the unused command code
// answer in the cycle after acceptance; a pop goes through the registered memory read
// and the POP and DONE states. Remove walks the stored entries through one comparator,
// one entry a cycle, reading ahead of the compacting write pointer, then passes through
// DONE. The block takes no new command word until the previous one has finished, and
// only in a cycle in which the output register is empty or its word is being taken.
// fill_level gives the low eight bits of the entry count.
module stack_with_key_removal_unit #(
	parameter int DEPTH = 128
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    cmd_valid,
	output logic                   cmd_stall,
	input  wire swkr_pkg::cmd_word_t cmd_word,
	output logic                   rsp_valid,
	input  wire                    rsp_stall,
	output swkr_pkg::rsp_word_t    rsp_word
);
	import swkr_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [CW-1:0] ONE_C   = CW'(1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_POP  = 4'b0010,
		ST_RM   = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	function automatic logic [7:0] fill8(input logic [CW-1:0] c);
		logic [CW+7:0] e;
		e = {8'd0, c};
		return e[7:0];
	endfunction

	state_t             state_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      rd_q;
	logic [CW-1:0]      wr_q;
	logic               rv_q;
	logic signed [31:0] key_q;
	rsp_word_t          res_q;
	rsp_word_t          out_q;
	logic               out_valid_q;

	logic signed [31:0] mem [DEPTH];
	logic signed [31:0] rdata_q;
	logic               we, re;
	logic [AW-1:0]      waddr, raddr;
	logic signed [31:0] wdata;

	logic               accept;
	logic               out_free;
	logic               load_out;
	logic [CW-1:0]      top;

	assign out_free  = !out_valid_q || !rsp_stall;
	assign cmd_stall = (state_q != ST_IDLE) || !out_free;
	assign accept    = cmd_valid && !cmd_stall;
	assign rsp_valid = out_valid_q;
	assign rsp_word  = out_q;
	assign top       = count_q - ONE_C;

	always_comb begin
		we       = 1'b0;
		re       = 1'b0;
		load_out = 1'b0;
		waddr    = count_q[AW-1:0];
		raddr    = top[AW-1:0];
		wdata    = cmd_word.value;
		if (state_q == ST_IDLE) begin
			if (accept && cmd_word.command == CMD_PUSH && count_q != DEPTH_C) begin
				we = 1'b1;
			end
			if (accept && cmd_word.command == CMD_POP && count_q != '0) begin
				re = 1'b1;
			end
			if (accept && cmd_word.command != CMD_REMOVE
			    && !(cmd_word.command == CMD_POP && count_q != '0)) begin
				load_out = 1'b1;
			end
		end else if (state_q == ST_RM) begin
			raddr = rd_q[AW-1:0];
			re    = (rd_q != count_q);
			waddr = wr_q[AW-1:0];
			wdata = rdata_q;
			we    = rv_q && (rdata_q != key_q);
		end else if (state_q == ST_DONE) begin
			load_out = out_free;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				key_q <= cmd_word.value;
				res_q <= '{popped_value: '0, status: STAT_OK, fill_level: fill8(count_q)};
			end
			ST_POP: begin
				res_q <= '{popped_value: rdata_q, status: STAT_OK, fill_level: fill8(count_q)};
			end
			ST_RM: begin
				if (rd_q == count_q && !rv_q) begin
					res_q <= '{popped_value: '0, status: STAT_OK, fill_level: fill8(wr_q)};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rd_q        <= '0;
			wr_q        <= '0;
			rv_q        <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					rd_q <= '0;
					wr_q <= '0;
					rv_q <= 1'b0;
					if (accept) begin
						case (cmd_word.command)
							CMD_PUSH: begin
								out_q.popped_value <= '0;
								if (count_q == DEPTH_C) begin
									out_q.status     <= STAT_FULL;
									out_q.fill_level <= fill8(count_q);
								end else begin
									count_q          <= count_q + ONE_C;
									out_q.status     <= STAT_OK;
									out_q.fill_level <= fill8(count_q + ONE_C);
								end
							end
							CMD_POP: begin
								if (count_q == '0) begin
									out_q       <= '{popped_value: '0, status: STAT_EMPTY,
									                 fill_level: fill8(count_q)};
								end else begin
									count_q <= top;
									state_q <= ST_POP;
								end
							end
							CMD_REMOVE: begin
								state_q <= ST_RM;
							end
							default: begin
								out_q       <= '{popped_value: '0, status: STAT_OK,
								                 fill_level: fill8(count_q)};
							end
						endcase
					end
				end
				ST_POP: begin
					state_q <= ST_DONE;
				end
				ST_RM: begin
					rv_q <= (rd_q != count_q);
					if (rd_q != count_q) begin
						rd_q <= rd_q + ONE_C;
					end
					if (rv_q && (rdata_q != key_q)) begin
						wr_q <= wr_q + ONE_C;
					end
					if (rd_q == count_q && !rv_q) begin
						count_q <= wr_q;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_q       <= res_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 1ps
module tb;
	import swkr_pkg::*;

	localparam int STACK_DEPTH = 128;
	localparam int LONG_HOLD = 300;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic clk;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	cmd_word_t cmd_word = '0;
	logic rsp_stall = 1'b0;
	logic cmd_stall;
	logic rsp_valid;
	rsp_word_t rsp_word;

	stack_with_key_removal_unit #(.DEPTH(STACK_DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd_word(cmd_word),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_word(rsp_word)
	);

	// shadow copy of the stack, updated as each command word is taken
	logic signed [31:0] shadow[STACK_DEPTH];
	int shadow_depth = 0;
	rsp_word_t due_responses[$];

	bit cmd_gaps_on = 1'b1;
	bit rsp_gaps_on = 1'b1;
	bit long_hold_req = 1'b0;

	int mismatches = 0;
	int words_checked = 0;
	int n_push = 0, n_pop = 0, n_remove = 0, n_unused = 0;
	int n_full = 0, n_empty = 0, n_removed = 0, peak_depth = 0;
	int idle_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic rsp_word_t apply_to_shadow_stack(cmd_word_t w);
		rsp_word_t r;
		int kept;
		r.popped_value = '0;
		r.status = STAT_OK;
		case (w.command)
			CMD_PUSH: begin
				n_push++;
				if (shadow_depth >= STACK_DEPTH) begin
					r.status = STAT_FULL;
					n_full++;
				end else begin
					shadow[shadow_depth] = w.value;
					shadow_depth++;
				end
			end
			CMD_POP: begin
				n_pop++;
				if (shadow_depth == 0) begin
					r.status = STAT_EMPTY;
					n_empty++;
				end else begin
					shadow_depth--;
					r.popped_value = shadow[shadow_depth];
				end
			end
			CMD_REMOVE: begin
				n_remove++;
				kept = 0;
				for (int i = 0; i < shadow_depth; i++) begin
					if (shadow[i] != w.value) begin
						shadow[kept] = shadow[i];
						kept++;
					end
				end
				n_removed += shadow_depth - kept;
				shadow_depth = kept;
			end
			default: n_unused++;
		endcase
		if (shadow_depth > peak_depth)
			peak_depth = shadow_depth;
		r.fill_level = shadow_depth[7:0];
		return r;
	endfunction

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2, 3: return $urandom;
			default: return 32'($urandom_range(0, 7)) - 32'd3;
		endcase
	endfunction

	function automatic logic signed [31:0] pick_key();
		if (shadow_depth > 0 && $urandom_range(0, 9) < 6)
			return shadow[$urandom_range(0, shadow_depth - 1)];
		return pick_value();
	endfunction

	task automatic send_word(input logic [1:0] op, input logic signed [31:0] val);
		cmd_word_t w;
		w.command = op;
		w.value = val;
		if (cmd_gaps_on && $urandom_range(0, 5) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_word <= w;
		do @(posedge clk); while (cmd_stall);
		due_responses.push_back(apply_to_shadow_stack(w));
	endtask

	task automatic send_random_op(input int push_w, input int pop_w);
		int r;
		r = $urandom_range(0, 99);
		if (r < push_w)
			send_word(CMD_PUSH, pick_value());
		else if (r < push_w + pop_w)
			send_word(CMD_POP, $urandom);
		else if (r < 96)
			send_word(CMD_REMOVE, pick_key());
		else
			send_word(CMD_UNUSED, $urandom);
	endtask

	task automatic wait_until_drained();
		cmd_valid <= 1'b0;
		while (due_responses.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed_cases();
		send_word(CMD_POP, 32'sh0);
		send_word(CMD_REMOVE, 32'sh0);
		send_word(CMD_PUSH, 32'sh7fffffff);
		send_word(CMD_PUSH, 32'sh80000000);
		send_word(CMD_PUSH, -32'sd1);
		send_word(CMD_PUSH, 32'sh0);
		send_word(CMD_PUSH, -32'sd1);
		send_word(CMD_PUSH, 32'sd1);
		send_word(CMD_UNUSED, $urandom);
		send_word(CMD_REMOVE, -32'sd1);
		send_word(CMD_REMOVE, 32'sd42);
		send_word(CMD_POP, 32'sh7fffffff);
		send_word(CMD_PUSH, 32'sh80000000);
		send_word(CMD_REMOVE, 32'sh80000000);
		send_word(CMD_POP, -32'sd1);
		send_word(CMD_POP, 32'sh0);
		send_word(CMD_POP, 32'sh0);
		send_word(CMD_PUSH, 32'sd7);
		send_word(CMD_PUSH, 32'sd7);
		send_word(CMD_REMOVE, 32'sd7);
		send_word(CMD_UNUSED, 32'shffffffff);
		wait_until_drained();
	endtask

	task automatic test_fill_to_capacity();
		while (shadow_depth < STACK_DEPTH)
			send_word(CMD_PUSH, pick_value());
		send_word(CMD_PUSH, 32'sh7fffffff);
		send_word(CMD_REMOVE, shadow[STACK_DEPTH / 2]);
		while (shadow_depth < STACK_DEPTH)
			send_word(CMD_PUSH, pick_value());
		send_word(CMD_PUSH, 32'sh80000000);
		send_word(CMD_REMOVE, 32'sh5a5a5a5a);
		while (shadow_depth > 0)
			send_word(CMD_POP, $urandom);
		send_word(CMD_POP, $urandom);
	endtask

	task automatic test_random_mix(input int count, input int push_w, input int pop_w);
		for (int i = 0; i < count; i++) begin
			if (i % 64 == 0) begin
				cmd_gaps_on = $urandom_range(0, 3) != 0;
				rsp_gaps_on = $urandom_range(0, 3) != 0;
			end
			send_random_op(push_w, pop_w);
		end
	endtask

	task automatic test_output_backpressure();
		cmd_gaps_on = 1'b0;
		long_hold_req = 1'b1;
		for (int i = 0; i < 30; i++)
			send_random_op(50, 35);
		cmd_gaps_on = 1'b1;
	endtask

	task automatic test_pause_until_drained();
		for (int round = 0; round < 3; round++) begin
			repeat ($urandom_range(10, 20))
				send_random_op(45, 30);
			wait_until_drained();
		end
	endtask

	task automatic test_back_to_back();
		cmd_gaps_on = 1'b0;
		rsp_gaps_on = 1'b0;
		for (int i = 0; i < 200; i++)
			send_random_op(i < 100 ? 60 : 30, i < 100 ? 20 : 50);
	endtask

	// response side hold-off
	initial begin
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				rsp_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				rsp_stall <= 1'b0;
			end else if (rsp_gaps_on && $urandom_range(0, 7) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 14)) @(posedge clk);
				rsp_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : check_rsp
		rsp_word_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			words_checked++;
			if (due_responses.size() == 0) begin
				$display("%0t: response word with none expected: got %p", $time, rsp_word);
				mismatches++;
			end else begin
				want = due_responses.pop_front();
				if (rsp_word.popped_value !== want.popped_value) begin
					$display("%0t: popped_value expected %0d got %0d", $time,
						want.popped_value, rsp_word.popped_value);
					mismatches++;
				end
				if (rsp_word.status !== want.status) begin
					$display("%0t: status expected %0d got %0d", $time,
						want.status, rsp_word.status);
					mismatches++;
				end
				if (rsp_word.fill_level !== want.fill_level) begin
					$display("%0t: fill_level expected %0d got %0d", $time,
						want.fill_level, rsp_word.fill_level);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
			idle_cycles <= 0;
		else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, idle_cycles);
			$display("stack_with_key_removal_unit test failed");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_fill_to_capacity();
		test_random_mix(400, 60, 15);
		test_output_backpressure();
		test_random_mix(400, 30, 45);
		test_pause_until_drained();
		test_random_mix(400, 45, 30);
		test_back_to_back();
		wait_until_drained();
		repeat (STACK_DEPTH + 16) @(posedge clk);
		$display("%0d words checked: %0d push, %0d pop, %0d remove, %0d unused code",
			words_checked, n_push, n_pop, n_remove, n_unused);
		$display("%0d full and %0d empty refusals, %0d entries removed, peak depth %0d",
			n_full, n_empty, n_removed, peak_depth);
		if (mismatches == 0 && due_responses.size() == 0)
			$display("stack_with_key_removal_unit test passed");
		else
			$display("stack_with_key_removal_unit test failed");
		$finish;
	end

endmodule

// File: stack_with_key_removal_unit.f
rtl/swkr_pkg.sv
rtl/stack_with_key_removal_unit.sv
verif/tb.sv
